/* hdl/greedy_coin_change_macros.svh */
// ----------------------------------------------------------------------------
// Greedy coin change assertion macros
// Shared helpers for the concurrent checks on the coin change block.
// ----------------------------------------------------------------------------
`ifndef GREEDY_COIN_CHANGE_MACROS_SVH
`define GREEDY_COIN_CHANGE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GCOIN_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gcoin check failed");

// Next-cycle implication, disabled while reset is asserted.
`define GCOIN_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gcoin check failed");

`endif

/* hdl/gcoin_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Greedy coin change package
// Field widths, the denomination table and the controller interface types.
// ----------------------------------------------------------------------------
package gcoin_pkg;

	localparam int AMOUNT_IN_BITS = 24;
	localparam int VALUE_BITS     = 16;
	localparam int COUNT_BITS     = 24;
	localparam int NUM_DENOM      = 15;
	localparam int DENOM_IDX_BITS = 4;

	localparam logic [VALUE_BITS-1:0]     FIRST_DENOM = 16'd50000;
	localparam logic [DENOM_IDX_BITS-1:0] LAST_IDX    = 4'(NUM_DENOM - 1);

	typedef struct packed {
		logic                      load;
		logic                      mul;
		logic                      first;
		logic                      step;
		logic [DENOM_IDX_BITS-1:0] idx;
	} cmd_t;

	typedef struct packed {
		logic rest_zero;
	} sts_t;

	function automatic logic [VALUE_BITS-1:0] denom_value(input logic [DENOM_IDX_BITS-1:0] idx);
		logic [VALUE_BITS-1:0] v;
		unique case (idx)
			4'd0:    v = 16'd50000;
			4'd1:    v = 16'd20000;
			4'd2:    v = 16'd10000;
			4'd3:    v = 16'd5000;
			4'd4:    v = 16'd2000;
			4'd5:    v = 16'd1000;
			4'd6:    v = 16'd500;
			4'd7:    v = 16'd200;
			4'd8:    v = 16'd100;
			4'd9:    v = 16'd50;
			4'd10:   v = 16'd20;
			4'd11:   v = 16'd10;
			4'd12:   v = 16'd5;
			4'd13:   v = 16'd2;
			4'd14:   v = 16'd1;
			default: v = 16'd0;
		endcase
		return v;
	endfunction

endpackage

/* hdl/gcoin_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Greedy coin change controller
// Sequences the load, the quotient multiply and one step per denomination until the rest is zero.
// ----------------------------------------------------------------------------
module gcoin_ctrl
	import gcoin_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  sts_t sts,
	output cmd_t cmd,
	output logic busy
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_MUL   = 2'd1;
	localparam logic [1:0] ST_FIRST = 2'd2;
	localparam logic [1:0] ST_STEP  = 2'd3;

	logic [1:0]                state_q;
	logic [1:0]                state_d;
	logic [DENOM_IDX_BITS-1:0] idx_q;
	logic [DENOM_IDX_BITS-1:0] idx_d;

	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		cmd.load  = 1'b0;
		cmd.mul   = 1'b0;
		cmd.first = 1'b0;
		cmd.step  = 1'b0;
		cmd.idx   = idx_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_FIRST;
			end
			ST_FIRST: begin
				cmd.first = 1'b1;
				idx_d     = 4'd1;
				state_d   = sts.rest_zero ? ST_IDLE : ST_STEP;
			end
			ST_STEP: begin
				cmd.step = 1'b1;
				if (sts.rest_zero || idx_q == LAST_IDX) begin
					state_d = ST_IDLE;
				end else begin
					idx_d = idx_q + 4'd1;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

/* hdl/gcoin_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Greedy coin change datapath
// Holds the remaining amount and running total and registers each result.
// ----------------------------------------------------------------------------
module gcoin_datapath
	import gcoin_pkg::*;
#(
	parameter int AMOUNT_BITS = 24
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cmd_t                      cmd,
	input  logic [AMOUNT_IN_BITS-1:0] amount_cents,
	output sts_t                      sts,
	output logic                      result_strobe,
	output logic [VALUE_BITS-1:0]     coin_value,
	output logic [COUNT_BITS-1:0]     coin_count,
	output logic [COUNT_BITS-1:0]     coins_so_far,
	output logic                      last
);

	localparam int SHIFT      = AMOUNT_BITS + 16;
	localparam int RECIP_BITS = AMOUNT_BITS + 1;
	localparam int QUOT_BITS  = AMOUNT_BITS - 15;
	localparam int PROD_BITS  = AMOUNT_BITS + RECIP_BITS;
	localparam int EXT_BITS   = (AMOUNT_BITS > AMOUNT_IN_BITS) ? AMOUNT_BITS : AMOUNT_IN_BITS;
	localparam logic [63:0] RECIP_FULL =
		((64'd1 << SHIFT) + 64'(FIRST_DENOM) - 64'd1) / 64'(FIRST_DENOM);
	localparam logic [RECIP_BITS-1:0] RECIP = RECIP_FULL[RECIP_BITS-1:0];

	logic [AMOUNT_BITS-1:0]  rest_q;
	logic [QUOT_BITS-1:0]    quot_q;
	logic [COUNT_BITS-1:0]   total_q;
	logic [EXT_BITS-1:0]     amount_ext;
	logic [PROD_BITS-1:0]    product;
	logic [AMOUNT_BITS:0]    sub_first;
	logic [AMOUNT_BITS:0]    rest_wide;
	logic [AMOUNT_BITS:0]    coin_wide;
	logic [AMOUNT_BITS:0]    coin_twice;
	logic [1:0]              step_count;
	logic [AMOUNT_BITS:0]    step_sub;
	logic [VALUE_BITS-1:0]   coin;
	logic [AMOUNT_BITS-1:0]  rest_new;
	logic [COUNT_BITS-1:0]   count_sel;
	logic [VALUE_BITS-1:0]   value_sel;
	logic                    emit;

	assign amount_ext = EXT_BITS'(amount_cents);
	assign product    = PROD_BITS'(rest_q) * PROD_BITS'(RECIP);
	assign sub_first  = (AMOUNT_BITS + 1)'(quot_q) * (AMOUNT_BITS + 1)'(FIRST_DENOM);

	assign coin       = denom_value(cmd.idx);
	assign rest_wide  = {1'b0, rest_q};
	assign coin_wide  = (AMOUNT_BITS + 1)'(coin);
	assign coin_twice = coin_wide << 1;

	always_comb begin
		if (rest_wide >= coin_twice) begin
			step_count = 2'd2;
			step_sub   = coin_twice;
		end else if (rest_wide >= coin_wide) begin
			step_count = 2'd1;
			step_sub   = coin_wide;
		end else begin
			step_count = 2'd0;
			step_sub   = '0;
		end
	end

	always_comb begin
		if (cmd.first) begin
			rest_new  = rest_q - sub_first[AMOUNT_BITS-1:0];
			count_sel = COUNT_BITS'(quot_q);
			value_sel = (quot_q != '0) ? FIRST_DENOM : '0;
			emit      = (quot_q != '0) || (rest_q == '0);
		end else begin
			rest_new  = rest_q - step_sub[AMOUNT_BITS-1:0];
			count_sel = COUNT_BITS'(step_count);
			value_sel = coin;
			emit      = cmd.step && (step_count != 2'd0);
		end
	end

	assign sts.rest_zero = (rest_new == '0);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rest_q  <= amount_ext[AMOUNT_BITS-1:0];
			total_q <= '0;
		end else if (cmd.first || cmd.step) begin
			rest_q  <= rest_new;
			total_q <= total_q + count_sel;
		end
		if (cmd.mul) begin
			quot_q <= product[SHIFT+QUOT_BITS-1:SHIFT];
		end
		if (emit) begin
			coin_value   <= value_sel;
			coin_count   <= count_sel;
			coins_so_far <= total_q + count_sel;
			last         <= sts.rest_zero;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_strobe <= 1'b0;
		end else begin
			result_strobe <= emit;
		end
	end

endmodule

/* hdl/greedy_coin_change.sv */
`timescale 1ns / 1ps
// Results follow a taken request after the reciprocal multiply, at most one per cycle.
// A request keeps busy high through the reciprocal multiply, the largest denomination and one
// step per further denomination until the remaining amount reaches zero or the last
// denomination is done, and a new request is taken only once busy is low again.
// Results cannot be held off by the receiver; each strobe lasts a single cycle.
// Reset clears the controller and the result strobe; payload registers are not reset.
// ----------------------------------------------------------------------------
// Greedy coin change
// Splits an amount in cents greedily over the euro denominations.
// ----------------------------------------------------------------------------
module greedy_coin_change
	import gcoin_pkg::*;
#(
	parameter int AMOUNT_BITS = 24
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [AMOUNT_IN_BITS-1:0] amount_cents,
	output logic                      result_strobe,
	output logic [VALUE_BITS-1:0]     coin_value,
	output logic [COUNT_BITS-1:0]     coin_count,
	output logic [COUNT_BITS-1:0]     coins_so_far,
	output logic                      last
);

	cmd_t cmd;
	sts_t sts;
	logic ctrl_busy;

	gcoin_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (ctrl_busy)
	);

	gcoin_datapath #(
		.AMOUNT_BITS (AMOUNT_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.amount_cents  (amount_cents),
		.sts           (sts),
		.result_strobe (result_strobe),
		.coin_value    (coin_value),
		.coin_count    (coin_count),
		.coins_so_far  (coins_so_far),
		.last          (last)
	);

	assign busy = ctrl_busy;

endmodule

/* hdl/gcoin_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Greedy coin change checker
// Port-level checks on request acceptance and result sequencing.
// ----------------------------------------------------------------------------
`include "greedy_coin_change_macros.svh"

module gcoin_checker
	import gcoin_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  start,
	input logic                  busy,
	input logic                  result_strobe,
	input logic [VALUE_BITS-1:0] coin_value,
	input logic [COUNT_BITS-1:0] coin_count,
	input logic [COUNT_BITS-1:0] coins_so_far,
	input logic                  last
);

	`GCOIN_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
	`GCOIN_ASSERT_SAME(a_zero_result, result_strobe && coin_value == '0, last && coin_count == '0 && coins_so_far == '0)
	`GCOIN_ASSERT_SAME(a_coin_used, result_strobe && coin_value != '0, coin_count != '0)
	`GCOIN_ASSERT_SAME(a_more_pending, result_strobe && !last, busy)
	`GCOIN_ASSERT_SAME(a_strobe_origin, result_strobe, $past(busy))

endmodule

bind greedy_coin_change gcoin_checker u_checker (.*);

/* tb/sv/coin_change_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coin change checker
// Watches the request and result ports of the coin change block. Each taken
// request is split greedily into euro denominations here, and every result
// strobe is compared field by field against the oldest predicted coin group.
// ----------------------------------------------------------------------------
module coin_change_checker
	import gcoin_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      busy,
	input  logic [AMOUNT_IN_BITS-1:0] amount_cents,
	input  logic                      result_strobe,
	input  logic [VALUE_BITS-1:0]     coin_value,
	input  logic [COUNT_BITS-1:0]     coin_count,
	input  logic [COUNT_BITS-1:0]     coins_so_far,
	input  logic                      last,
	output int                        fail_count,
	output int                        pending
);

	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
		logic [COUNT_BITS-1:0] count;
		logic [COUNT_BITS-1:0] so_far;
		logic                  last;
	} coin_group_t;

	localparam int unsigned EURO_CENTS [NUM_DENOM] = '{
		50000, 20000, 10000, 5000, 2000, 1000, 500, 200,
		100, 50, 20, 10, 5, 2, 1
	};

	coin_group_t expected_coins [$];

	initial begin
		fail_count = 0;
		pending    = 0;
	end

	function automatic void split_into_coins(input logic [AMOUNT_IN_BITS-1:0] amount);
		logic [31:0] rest;
		logic [31:0] count;
		logic [31:0] total;
		coin_group_t grp;
		rest  = 32'(amount);
		total = '0;
		if (rest == 0) begin
			grp.value  = '0;
			grp.count  = '0;
			grp.so_far = '0;
			grp.last   = 1'b1;
			expected_coins.insert(expected_coins.size(), grp);
		end else begin
			for (int d = 0; d < NUM_DENOM && rest != 0; d++) begin
				count = rest / EURO_CENTS[d];
				if (count != 0) begin
					rest       = rest - count * EURO_CENTS[d];
					total      = total + count;
					grp.value  = VALUE_BITS'(EURO_CENTS[d]);
					grp.count  = COUNT_BITS'(count);
					grp.so_far = COUNT_BITS'(total);
					grp.last   = (rest == 0);
					expected_coins.insert(expected_coins.size(), grp);
				end
			end
		end
	endfunction

	function automatic void compare_field(input string name, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endfunction

	// Results are checked before a new request is predicted, so a strobe on the
	// same edge as an accepted request is matched against the older one.
	always @(posedge clk) begin
		coin_group_t want;
		if (arst_n) begin
			if (result_strobe) begin
				if (expected_coins.size() == 0) begin
					$error("unexpected result: coin_value %0d coin_count %0d", coin_value,
						coin_count);
					fail_count++;
				end else begin
					want = expected_coins.pop_front();
					compare_field("coin_value", want.value, coin_value);
					compare_field("coin_count", want.count, coin_count);
					compare_field("coins_so_far", want.so_far, coins_so_far);
					compare_field("last", want.last, last);
				end
			end
			if (start && !busy)
				split_into_coins(amount_cents);
		end
		pending <= expected_coins.size();
	end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coin change testbench
// Drives directed and random amounts into the coin change block under several
// sender idling patterns, lets a separate checker predict and compare every
// result, and reports the verdict once all requests have been answered.
// ----------------------------------------------------------------------------
module tb_top;
	import gcoin_pkg::*;

	logic                      clk;
	logic                      arst_n       = 1'b0;
	logic                      start        = 1'b0;
	logic [AMOUNT_IN_BITS-1:0] amount_cents = '0;
	logic                      busy;
	logic                      result_strobe;
	logic [VALUE_BITS-1:0]     coin_value;
	logic [COUNT_BITS-1:0]     coin_count;
	logic [COUNT_BITS-1:0]     coins_so_far;
	logic                      last;
	int                        fail_count;
	int                        pending;
	int                        idle_pct = 0;

	greedy_coin_change uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.amount_cents  (amount_cents),
		.result_strobe (result_strobe),
		.coin_value    (coin_value),
		.coin_count    (coin_count),
		.coins_so_far  (coins_so_far),
		.last          (last)
	);

	coin_change_checker change_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.amount_cents  (amount_cents),
		.result_strobe (result_strobe),
		.coin_value    (coin_value),
		.coin_count    (coin_count),
		.coins_so_far  (coins_so_far),
		.last          (last),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	initial begin
		#20_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic logic [AMOUNT_IN_BITS-1:0] pick_amount();
		logic [31:0] amt;
		case ($urandom_range(9))
			0:       amt = 0;
			1, 2:    amt = $urandom_range(999);
			3, 4:    amt = $urandom_range(200000);
			5:       amt = 50000 * $urandom_range(335) + $urandom_range(9);
			6, 7:    amt = $urandom;
			default: amt = $urandom_range(99999);
		endcase
		return AMOUNT_IN_BITS'(amt);
	endfunction

	// Called at a rising edge; returns at the edge on which the request is taken.
	task automatic request_change(input logic [AMOUNT_IN_BITS-1:0] amt);
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			start        <= 1'b0;
			amount_cents <= AMOUNT_IN_BITS'($urandom);
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		start        <= 1'b1;
		amount_cents <= amt;
		do @(posedge clk); while (busy);
	endtask

	task automatic pause_until_drained();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (20) @(posedge clk);
	endtask

	initial begin
		logic [AMOUNT_IN_BITS-1:0] directed [] = '{
			0, 1, 2, 3, 4, 5, 9, 10, 20, 50, 49999, 50000, 50001, 88888, 99999,
			100000, 12345, 24'hAAAAAA, 24'h555555, 24'hFFFFFE, 24'hFFFFFF
		};
		int phase_idle [4] = '{0, 64, 28, 0};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i])
			request_change(directed[i]);
		pause_until_drained();
		for (int p = 0; p < 4; p++) begin
			idle_pct = phase_idle[p];
			repeat (75)
				request_change(pick_amount());
			pause_until_drained();
		end
		if (fail_count == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
